// ===== src/bmc_pkg.sv =====
package bmc_pkg;

  // Default for the largest supported line length.
  localparam int DEF_MAX_WIDTH = 1024;

  // Configuration port.
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 16;
  localparam int FW_BITS       = 11;
  localparam int FH_BITS       = 16;
  localparam logic [FW_BITS-1:0] FW_RESET = 11'd640;
  localparam logic [FH_BITS-1:0] FH_RESET = 16'd480;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Row counters run a few rows past the frame height while the pipe flushes.
  localparam int ROW_BITS = 17;

  // Output queue entries.
  localparam int FIFO_DEPTH = 8;

  // Side information that travels with every pixel through a window stage.
  typedef struct packed {
    logic center_ok;  // the window center is a pixel of the frame or of its flush
    logic emit;       // this item produces a result word
    logic fin;        // the result is the last pixel of the frame
  } tag_t;

endpackage

// ===== src/bmc_ram.sv =====
module bmc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bmc_win3.sv =====
// One 3x3 window pass over a raster bit stream. A line memory indexed by
// column keeps the two previous rows; three column registers form the window.
// An item goes through the line memory read stage and then the window stage to its result.
module bmc_win3 #(
  parameter int MAX_WIDTH = bmc_pkg::DEF_MAX_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 grow,       // 1: OR window, 0: AND window
  input  logic [$clog2(MAX_WIDTH+1)-1:0]       width,
  input  logic [bmc_pkg::FH_BITS-1:0]          height,
  input  logic                                 in_valid,
  input  bmc_pkg::tag_t                        in_tag,
  input  logic [$clog2(MAX_WIDTH)-1:0]         in_x,
  input  logic [bmc_pkg::ROW_BITS-1:0]         in_y,
  input  logic                                 in_bit,
  output logic                                 out_valid,
  output bmc_pkg::tag_t                        out_tag,
  output logic [$clog2(MAX_WIDTH)-1:0]         out_x,
  output logic [bmc_pkg::ROW_BITS-1:0]         out_y,
  output logic                                 out_bit,
  output logic [1:0]                           busy_emit
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RB = bmc_pkg::ROW_BITS;

  // First stage: line memory read in flight.
  logic                a_valid_r;
  bmc_pkg::tag_t       a_tag_r;
  logic [CW-1:0]       a_x_r;
  logic [RB-1:0]       a_y_r;
  logic                a_bit_r;

  // Write of the previous cycle, for a read that raced it.
  logic                f_valid_r;
  logic [CW-1:0]       f_addr_r;
  logic [1:0]          f_data_r;

  // Second stage: window complete, center known.
  logic                b_valid_r;
  bmc_pkg::tag_t       b_tag_r;
  logic [CW-1:0]       b_x_r;
  logic [RB-1:0]       b_y_r;
  logic                b_border_r;

  logic [2:0]          win_r [3];

  logic [1:0]          ram_rd;
  logic [1:0]          line;
  logic [1:0]          wr_data;
  logic [2:0]          vec;
  logic [CW-1:0]       cx;
  logic [RB-1:0]       cy;
  logic                border;

  // Word bit 0 holds the row above, bit 1 the row two above.
  bmc_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (a_valid_r),
    .waddr (a_x_r),
    .wdata (wr_data),
    .raddr (in_x),
    .rdata (ram_rd)
  );

  always_comb begin
    line    = (f_valid_r && (f_addr_r == a_x_r)) ? f_data_r : ram_rd;
    wr_data = {line[0], a_bit_r};
    vec     = {a_bit_r, line[0], line[1]};
    if (a_x_r != '0) begin
      cx = a_x_r - CW'(1);
      cy = a_y_r - RB'(1);
    end else begin
      cx = CW'(width - WW'(1));
      cy = a_y_r - RB'(2);
    end
    border = (cx == '0) || ((32'(cx) + 32'd1) >= 32'(width)) ||
             (cy == '0) || ((32'(cy) + 32'd1) >= 32'(height));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      f_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
      f_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_tag_r <= in_tag;
    a_x_r   <= in_x;
    a_y_r   <= in_y;
    a_bit_r <= in_bit;
    f_addr_r <= a_x_r;
    f_data_r <= wr_data;
    b_tag_r    <= a_tag_r;
    b_x_r      <= cx;
    b_y_r      <= cy;
    b_border_r <= border;
    if (a_valid_r) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= vec;
    end
  end

  // The middle column's middle bit is always the window center.
  always_comb begin
    out_valid = b_valid_r && b_tag_r.center_ok;
    out_tag   = b_tag_r;
    out_x     = b_x_r;
    out_y     = b_y_r;
    if (b_border_r) begin
      out_bit = win_r[1][1];
    end else if (grow) begin
      out_bit = |{win_r[0], win_r[1], win_r[2]};
    end else begin
      out_bit = &{win_r[0], win_r[1], win_r[2]};
    end
    busy_emit = 2'(a_valid_r && a_tag_r.emit) + 2'(b_valid_r && b_tag_r.emit);
  end

endmodule

// ===== src/binary_mask_close_3x3.sv =====
// Binary 3x3 closing (dilation followed by erosion with a square) of a mask
// streamed in raster order. One word is taken per clock, every clock, as long
// as the small output queue has room; both passes use a line memory that does
// one read and one write each cycle, so nothing in the datapath limits the
// rate below one pixel per clock. The closed bit of a pixel is released when
// the item 2*W+2 positions later arrives (W is the effective width), plus the
// pipeline registers. After the last real pixel of a frame, send 2*W+2 more
// words (drain words, or real pixels whose value is then ignored) to flush the
// frame; the word that flushes the last pixel carries tlast. A drain word that
// arrives inside a frame is consumed and ignored. Pixels in the outer ring of
// the frame keep their value in each pass. A width of zero counts as one and a
// width above MAX_WIDTH is clipped; a height of zero counts as one. Write the
// size registers only between frames. No clearing pass is needed after reset.
module binary_mask_close_3x3 #(
  parameter int MAX_WIDTH = bmc_pkg::DEF_MAX_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input stream.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,   // [0] pixel_in
  input  logic [0:0]                           in_tuser,   // [0] drain
  // Result stream.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [7:0]                           out_tdata,  // [0] pixel_out
  output logic                                 out_tlast,  // frame_end
  // Configuration writes.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bmc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [bmc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int RB  = bmc_pkg::ROW_BITS;
  localparam int FD  = bmc_pkg::FIFO_DEPTH;
  localparam int FPW = $clog2(FD);
  localparam int FCW = $clog2(FD + 1);

  // Size registers.
  logic [bmc_pkg::FW_BITS-1:0] cfg_fw_r;
  logic [bmc_pkg::FH_BITS-1:0] cfg_fh_r;
  logic [WW-1:0]               eff_w;
  logic [bmc_pkg::FH_BITS-1:0] eff_h;

  // Raster position of the next counted word (it runs on past the frame
  // while the pipe flushes).
  logic [CW-1:0] kc_r, kc_nxt;
  logic [RB-1:0] kr_r, kr_nxt;

  logic          acc;
  logic          in_frame;
  logic          counted;
  logic          pix;
  bmc_pkg::tag_t tag0;

  // Window stage links.
  logic          s1_valid;
  bmc_pkg::tag_t s1_tag;
  logic [CW-1:0] s1_x;
  logic [RB-1:0] s1_y;
  logic          s1_bit;
  logic [1:0]    s1_busy;
  bmc_pkg::tag_t s2_in_tag;
  logic          s2_valid;
  bmc_pkg::tag_t s2_tag;
  logic [CW-1:0] s2_x;
  logic [RB-1:0] s2_y;
  logic          s2_bit;
  logic [1:0]    s2_busy;

  // Output queue.
  logic [1:0]     fifo_mem [FD];
  logic [FPW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FCW-1:0] cnt_r, cnt_nxt;
  logic           push;
  logic           pop;
  logic [FCW:0]   used;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_fw_r <= bmc_pkg::FW_RESET;
      cfg_fh_r <= bmc_pkg::FH_RESET;
    end else if (cfg_valid) begin
      unique case (bmc_pkg::cfg_reg_t'(cfg_index))
        bmc_pkg::REG_FRAME_WIDTH:  cfg_fw_r <= cfg_data[bmc_pkg::FW_BITS-1:0];
        bmc_pkg::REG_FRAME_HEIGHT: cfg_fh_r <= cfg_data[bmc_pkg::FH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_fw_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(cfg_fw_r) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(cfg_fw_r);
    end
    eff_h = (cfg_fh_r == '0) ? bmc_pkg::FH_BITS'(1) : cfg_fh_r;
  end

  // ---------------------------------------------------------------------------
  // Input side: raster position and per-word flags
  // ---------------------------------------------------------------------------
  // The queue must hold every result still in the pipe plus this one.
  assign used      = (FCW+1)'(cnt_r) + (FCW+1)'(s1_busy) + (FCW+1)'(s2_busy);
  assign in_tready = used < (FCW+1)'(FD);

  always_comb begin
    acc      = in_tvalid && in_tready;
    in_frame = 32'(kr_r) < 32'(eff_h);
    // A drain word inside the frame does nothing at all.
    counted  = acc && !(in_frame && in_tuser[0]);
    pix      = in_frame & in_tdata[0];
    // Frame index k = kr*W + kc. The dilation center k-W-1 exists once
    // k >= W+1; the result for k-2W-2 is due once k >= 2W+2.
    tag0.center_ok = (kr_r >= RB'(2)) || ((kr_r == RB'(1)) && (kc_r != '0));
    tag0.emit      = ((kr_r >= RB'(3)) && !((eff_w == WW'(1)) && (kr_r == RB'(3)))) ||
                     ((kr_r == RB'(2)) && (kc_r >= CW'(2)));
    // Last result of the frame is due at k = (H+2)*W + 1.
    if (eff_w == WW'(1)) begin
      tag0.fin = 32'(kr_r) == (32'(eff_h) + 32'd3);
    end else begin
      tag0.fin = (32'(kr_r) == (32'(eff_h) + 32'd2)) && (kc_r == CW'(1));
    end

    kc_nxt = kc_r;
    kr_nxt = kr_r;
    if (counted) begin
      if (tag0.fin) begin
        kc_nxt = '0;
        kr_nxt = '0;
      end else if ((32'(kc_r) + 32'd1) >= 32'(eff_w)) begin
        kc_nxt = '0;
        kr_nxt = kr_r + RB'(1);
      end else begin
        kc_nxt = kc_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kc_r <= '0;
      kr_r <= '0;
    end else begin
      kc_r <= kc_nxt;
      kr_r <= kr_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Dilation pass, then erosion pass of the dilated stream
  // ---------------------------------------------------------------------------
  bmc_win3 #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dilate (
    .clk       (clk),
    .rst_n     (rst_n),
    .grow      (1'b1),
    .width     (eff_w),
    .height    (eff_h),
    .in_valid  (counted),
    .in_tag    (tag0),
    .in_x      (kc_r),
    .in_y      (kr_r),
    .in_bit    (pix),
    .out_valid (s1_valid),
    .out_tag   (s1_tag),
    .out_x     (s1_x),
    .out_y     (s1_y),
    .out_bit   (s1_bit),
    .busy_emit (s1_busy)
  );

  // In the second pass the window center is a result pixel exactly when the
  // word emits.
  always_comb begin
    s2_in_tag.center_ok = s1_tag.emit;
    s2_in_tag.emit      = s1_tag.emit;
    s2_in_tag.fin       = s1_tag.fin;
  end

  bmc_win3 #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_erode (
    .clk       (clk),
    .rst_n     (rst_n),
    .grow      (1'b0),
    .width     (eff_w),
    .height    (eff_h),
    .in_valid  (s1_valid),
    .in_tag    (s2_in_tag),
    .in_x      (s1_x),
    .in_y      (s1_y),
    .in_bit    (s1_bit),
    .out_valid (s2_valid),
    .out_tag   (s2_tag),
    .out_x     (s2_x),
    .out_y     (s2_y),
    .out_bit   (s2_bit),
    .busy_emit (s2_busy)
  );

  // ---------------------------------------------------------------------------
  // Output queue
  // ---------------------------------------------------------------------------
  assign push = s2_valid && s2_tag.emit;
  assign pop  = out_tvalid && out_tready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + FCW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - FCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FPW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FPW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= {s2_tag.fin, s2_bit};
    end
  end

  assign out_tvalid = cnt_r != '0;
  assign out_tdata  = {7'b0, fifo_mem[rd_ptr_r][0]};
  assign out_tlast  = fifo_mem[rd_ptr_r][1];

`ifndef SYNTHESIS
  // The credit check must keep the queue from ever overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ((cnt_r < FCW'(FD)) || pop))
    else $error("output queue overflow");

  // Results in the queue plus those in flight never exceed the queue depth.
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    used <= (FCW+1)'(FD))
    else $error("more results in flight than queue space");

  // The word that flushes the last pixel restarts the raster position.
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (counted && tag0.fin) |=> ((kc_r == '0) && (kr_r == '0)))
    else $error("raster position not cleared at frame end");

  // A word that emits a result always has a dilation center.
  a_emit_center: assert property (@(posedge clk) disable iff (!rst_n)
    (counted && tag0.emit) |-> tag0.center_ok)
    else $error("result due before its dilation center exists");
`endif

endmodule

// ===== tb/tb.sv =====
module tb;

  // Largest line the block supports; the line stores of the closing
  // predictor hold two lines plus a few words, indexed modulo their depth.
  localparam int MAX_W   = bmc_pkg::DEF_MAX_WIDTH;
  localparam int RING    = 2 * MAX_W + 4;
  // Cycles to let pass once nothing is expected, so that ignored drain words
  // still inside the pipeline are gone before a size register changes.
  localparam int SETTLE  = 16;
  // Hard stop for the whole run, in time units.
  localparam int TIMEOUT = 8_000_000;

  // One word of the input stream and one closed pixel of the result stream.
  typedef struct packed {
    logic pix;
    logic drain;
  } mask_word_t;

  typedef struct packed {
    logic pix;
    logic fin;
  } closed_px_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [7:0]                        in_tdata = '0;    // [0] pixel_in
  logic [0:0]                        in_tuser = '0;    // [0] drain
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [7:0]                        out_tdata;        // [0] pixel_out
  logic                              out_tlast;        // frame_end
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  bmc_pkg::cfg_reg_t                 cfg_index = bmc_pkg::REG_FRAME_WIDTH;
  logic [bmc_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  binary_mask_close_3x3 #(.MAX_WIDTH(MAX_W)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Words waiting for the driver, and closed pixels predicted but not yet seen.
  mask_word_t mask_q[$];
  closed_px_t closed_q[$];
  int unsigned errors = 0;

  // Idling controls, set per phase by the stimulus. During a burst neither
  // side idles, so every phase also has stretches at full rate.
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          burst = 1'b0;
  int unsigned burst_cnt = 0;
  // Set at the rising edge when an input word was taken, read by the driver.
  bit          in_taken = 1'b0;

  // ---------------------------------------------------------------------
  // Closing predictor: its own copy of the size registers, the two line
  // stores (source mask and dilated mask) and the raster counters.
  // ---------------------------------------------------------------------
  logic [bmc_pkg::FW_BITS-1:0] width_reg = bmc_pkg::FW_RESET;
  logic [bmc_pkg::FH_BITS-1:0] height_reg = bmc_pkg::FH_RESET;
  bit          src_ring[RING];
  bit          dil_ring[RING];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  int unsigned flush_cnt = 0;
  int unsigned next_out = 0;

  // A width of zero counts as one and anything above the line store is clipped.
  function automatic int unsigned eff_width(input logic [bmc_pkg::FW_BITS-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_W) return MAX_W;
    return 32'(v);
  endfunction

  function automatic int unsigned eff_height(input logic [bmc_pkg::FH_BITS-1:0] v);
    return (v == 0) ? 1 : 32'(v);
  endfunction

  // Pixels in the outer ring of the frame pass through both passes unchanged.
  function automatic bit is_border(input int unsigned i, input int unsigned w,
                                   input int unsigned h);
    int unsigned x;
    int unsigned y;
    x = i % w;
    y = i / w;
    return (x == 0) || (x + 1 >= w) || (y == 0) || (y + 1 >= h);
  endfunction

  // OR over the 3x3 window of the source mask (dilation) or AND over the
  // window of the dilated mask (erosion), centered on raster index c.
  function automatic bit window_fold(input int unsigned c, input int unsigned w,
                                     input bit grow);
    int unsigned base;
    int unsigned idx;
    bit          acc;
    bit          v;
    base = c - w - 1;
    acc = !grow;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        idx = (base + r * w + k) % RING;
        v = grow ? src_ring[idx] : dil_ring[idx];
        acc = grow ? (acc | v) : (acc & v);
      end
    end
    return acc;
  endfunction

  // Takes one accepted word and returns 1 when it releases a closed pixel.
  // A word at raster index k finishes the dilation of pixel k-W-1 and the
  // erosion of pixel k-2W-2. Once the frame's pixels are in, every word
  // counts as a flush word; the result with the frame end resets the counters.
  function automatic bit close_step(input bit pix, input bit drn,
                                    output bit res_pix, output bit res_fin);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned k;
    int unsigned j;
    int unsigned p;
    res_pix = 1'b0;
    res_fin = 1'b0;
    w = eff_width(width_reg);
    h = eff_height(height_reg);
    total = w * h;
    if (row_pos < h) begin
      // Drain words inside the frame are dropped without a trace.
      if (drn) return 1'b0;
      k = row_pos * w + col_pos;
      src_ring[k % RING] = pix;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
    end else begin
      k = total + flush_cnt;
      flush_cnt++;
    end
    if (k >= w + 1) begin
      j = k - w - 1;
      if (j < total) begin
        dil_ring[j % RING] = is_border(j, w, h) ? src_ring[j % RING] :
                                                  window_fold(j, w, 1'b1);
      end
    end
    if (k >= 2 * w + 2) begin
      p = next_out;
      res_fin = (p + 1 >= total);
      res_pix = is_border(p, w, h) ? dil_ring[p % RING] : window_fold(p, w, 1'b0);
      if (res_fin) begin
        col_pos = 0;
        row_pos = 0;
        flush_cnt = 0;
        next_out = 0;
      end else begin
        next_out = p + 1;
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge. Results are checked
  // first; a word taken at this edge cannot have a result out yet.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : watch
    closed_px_t got;
    closed_px_t want;
    bit         rp;
    bit         rf;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[0], out_tlast};
        if (closed_q.size() == 0) begin
          errors++;
          $display("%0t: expected no result word, actual pixel_out=%0b frame_end=%0b",
                   $time, got.pix, got.fin);
        end else begin
          want = closed_q.pop_front();
          if (got.pix !== want.pix) begin
            errors++;
            $display("%0t: pixel_out expected %0b actual %0b",
                     $time, want.pix, got.pix);
          end
          if (got.fin !== want.fin) begin
            errors++;
            $display("%0t: frame_end expected %0b actual %0b",
                     $time, want.fin, got.fin);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bmc_pkg::REG_FRAME_WIDTH) begin
          width_reg = cfg_data[bmc_pkg::FW_BITS-1:0];
        end else begin
          height_reg = cfg_data[bmc_pkg::FH_BITS-1:0];
        end
      end
      in_taken = in_tvalid && in_tready;
      if (in_taken) begin
        if (close_step(in_tdata[0], in_tuser[0], rp, rf)) closed_q.push_back('{rp, rf});
      end
    end else begin
      in_taken = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Driver: inputs change at the falling edge. A word stays on the bus until
  // it is taken; only then may the sender pick the next one or go idle.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin : drive
    mask_word_t wd;
    if (rst_n) begin
      burst_cnt++;
      if (burst_cnt % 48 == 0) burst = ($urandom_range(3) == 0);
      out_tready <= burst || ($urandom_range(99) >= stall_pct);
      if (!in_tvalid || in_taken) begin
        if (mask_q.size() != 0 && (burst || $urandom_range(99) >= idle_pct)) begin
          wd = mask_q.pop_front();
          in_tdata  <= {7'd0, wd.pix};
          in_tuser  <= wd.drain;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus. The generator keeps its own view of where the stream stands
  // in the frame, so that every phase can be brought back to a frame
  // boundary before the size registers change.
  // ---------------------------------------------------------------------
  int unsigned gen_w = 1;
  int unsigned gen_h = 1;
  int unsigned gen_pos = 0;
  int unsigned gen_flush = 0;
  int unsigned words_sent = 0;

  task automatic put_word(input bit pix, input bit drn);
    mask_q.push_back('{pix, drn});
    words_sent++;
    if (gen_pos < gen_w * gen_h) begin
      if (!drn) gen_pos++;
    end else begin
      gen_flush++;
      if (gen_flush == 2 * gen_w + 2) begin
        gen_pos = 0;
        gen_flush = 0;
      end
    end
  endtask

  // Waits until all queued words are taken and every predicted result has
  // arrived, then lets the pipeline settle.
  task automatic wait_quiet();
    while (mask_q.size() != 0 || in_tvalid || closed_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input bmc_pkg::cfg_reg_t idx,
                           input logic [bmc_pkg::CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Only called with the block idle and the stream at a frame boundary.
  task automatic set_size(input logic [15:0] wv, input logic [15:0] hv);
    write_reg(bmc_pkg::REG_FRAME_WIDTH, wv);
    write_reg(bmc_pkg::REG_FRAME_HEIGHT, hv);
    gen_w = eff_width(wv[bmc_pkg::FW_BITS-1:0]);
    gen_h = eff_height(hv);
  endtask

  // Completes an unfinished frame. With drains off, the flush is done by
  // real pixels, whose values the block must drop.
  task automatic finish_frame(input bit use_drains);
    while (gen_pos != 0 || gen_flush != 0)
      put_word(1'($urandom_range(1)), use_drains && gen_pos >= gen_w * gen_h &&
                                      $urandom_range(1) == 1);
  endtask

  // One frame at the given density of set pixels, with stray drains inside
  // it. A cut frame stops its flush early; the next call first finishes it
  // with real pixel words.
  task automatic send_frame(input int unsigned dens, input bit cut);
    int unsigned f;
    finish_frame(1'b0);
    for (int unsigned n = 0; n < gen_w * gen_h; n++) begin
      if ($urandom_range(19) == 0) put_word(1'($urandom_range(1)), 1'b1);
      put_word($urandom_range(99) < dens, 1'b0);
    end
    f = cut ? $urandom_range(2 * gen_w + 1) : 2 * gen_w + 2;
    repeat (f) put_word(1'($urandom_range(1)), $urandom_range(3) != 0);
  endtask

  // Random groups of frames, each group at a fresh size. The upper bits of
  // the width write are junk that the register must not keep.
  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned word_budget);
    int unsigned start;
    int unsigned wv;
    int unsigned hv;
    int unsigned dens;
    bit          held;
    idle_pct = idle;
    stall_pct = stall;
    start = words_sent;
    held = 1'b0;
    while (words_sent - start < word_budget) begin
      case ($urandom_range(9))
        0: wv = 0;
        1: wv = 1;
        2: wv = 2;
        8: wv = $urandom_range(9, 16);
        9: wv = $urandom_range(17, 40);
        default: wv = $urandom_range(3, 8);
      endcase
      hv = (wv > 16) ? $urandom_range(1, 3) : $urandom_range(0, 8);
      set_size({5'($urandom_range(31)), 11'(wv)}, 16'(hv));
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(4))
          0: dens = 5;
          1: dens = 30;
          2: dens = 50;
          3: dens = 70;
          default: dens = 95;
        endcase
        send_frame(dens, $urandom_range(3) == 0);
        // Hold the sender back until every predicted result is out, often
        // in the middle of a frame whose flush was cut short.
        if (!held || $urandom_range(4) == 0) begin
          wait_quiet();
          held = 1'b1;
        end
      end
      finish_frame(1'b1);
      wait_quiet();
    end
  endtask

  initial begin : stimulus
    logic [8:0] ring_hole;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: width and height of zero both count as one. A stray drain
    // first, then the only pixel, then four flush words of which the first
    // is a real pixel with a value that must be dropped.
    set_size(16'h0000, 16'h0000);
    put_word(1'b1, 1'b1);
    put_word(1'b1, 1'b0);
    put_word(1'b0, 1'b0);
    put_word(1'b1, 1'b1);
    put_word(1'b0, 1'b1);
    put_word(1'b1, 1'b1);
    wait_quiet();

    // Directed: a 3x3 ring of set pixels around a hole that closing fills.
    set_size(16'd3, 16'd3);
    ring_hole = 9'b111_101_111;
    for (int i = 0; i < 9; i++) put_word(ring_hole[i], 1'b0);
    for (int i = 0; i < 8; i++) put_word(i[0], i != 2);
    wait_quiet();

    run_phase(0, 0, 400);
    run_phase(78, 0, 400);
    run_phase(0, 78, 400);
    run_phase(32, 32, 400);

    wait_quiet();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #TIMEOUT;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
